// ===== hdl/brew_preinfusion_sequencer_defines.svh =====
// Assertion macros used by the brew pre-infusion sequencer core.
`ifndef BREW_PREINFUSION_SEQUENCER_DEFINES_SVH
`define BREW_PREINFUSION_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BPS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bps_pkg.sv =====
// Types and constants shared by the brew pre-infusion sequencer modules.
package bps_pkg;

    localparam int MS_W  = 16;
    localparam int CFG_W = 16;
    localparam int IDX_W = 3;

    // Phase codes as reported on the result word.
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PUMP  = 2'd1;
    localparam logic [1:0] PH_DELAY = 2'd2;
    localparam logic [1:0] PH_BREW  = 2'd3;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_PI_ENABLE = 3'd0;
    localparam logic [IDX_W-1:0] REG_PI_PUMP   = 3'd1;
    localparam logic [IDX_W-1:0] REG_PI_DELAY  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BT_ENABLE = 3'd3;
    localparam logic [IDX_W-1:0] REG_BT_LIMIT  = 3'd4;

    typedef struct packed {
        logic            preinfusion_enable;
        logic [MS_W-1:0] preinfusion_pump_ms;
        logic [MS_W-1:0] preinfusion_delay_ms;
        logic            brew_timer_enable;
        logic [MS_W-1:0] brew_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic            pump_on;
        logic            valve_on;
        logic [1:0]      phase;
        logic [MS_W-1:0] elapsed_ms;
        logic            brew_done;
    } t_result;

endpackage

// ===== hdl/bps_in_if.sv =====
// Input channel interface: one brew pass word per handshake.
interface bps_in_if #(
    parameter int TIME_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] now_ms;
    logic                 first_pass;

    modport source (output valid, output now_ms, output first_pass, input ready);
    modport sink   (input valid, input now_ms, input first_pass, output ready);
endinterface

// ===== hdl/bps_out_if.sv =====
// Output channel interface: one result word per handshake.
interface bps_out_if;
    logic        valid;
    logic        ready;
    logic        pump_on;
    logic        valve_on;
    logic [1:0]  phase;
    logic [15:0] elapsed_ms;
    logic        brew_done;

    modport source (output valid, output pump_on, output valve_on, output phase,
                    output elapsed_ms, output brew_done, input ready);
    modport sink   (input valid, input pump_on, input valve_on, input phase,
                    input elapsed_ms, input brew_done, output ready);
endinterface

// ===== hdl/bps_cfg_regs.sv =====
// Configuration register bank of the brew pre-infusion sequencer.
module bps_cfg_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [bps_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [bps_pkg::CFG_W-1:0] i_cfg_data,
    output bps_pkg::t_cfg            o_cfg
);
    import bps_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PI_ENABLE: n_cfg.preinfusion_enable   = i_cfg_data[0];
                REG_PI_PUMP:   n_cfg.preinfusion_pump_ms  = i_cfg_data[MS_W-1:0];
                REG_PI_DELAY:  n_cfg.preinfusion_delay_ms = i_cfg_data[MS_W-1:0];
                REG_BT_ENABLE: n_cfg.brew_timer_enable    = i_cfg_data[0];
                REG_BT_LIMIT:  n_cfg.brew_limit_ms        = i_cfg_data[MS_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/bps_core.sv =====
// Phase sequencer: holds the brew cycle state and computes one result per pass.
`include "brew_preinfusion_sequencer_defines.svh"

module bps_core #(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic                 i_first,
    input  bps_pkg::t_cfg        i_cfg,
    output bps_pkg::t_result     o_res
);
    import bps_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_PUMP  = 2'd1,
        S_DELAY = 2'd2,
        S_BREW  = 2'd3
    } t_state;

    t_state               r_state, n_state;
    logic [TIME_BITS-1:0] r_start, n_start;
    logic                 r_pend,  n_pend;
    logic                 r_pump,  n_pump;
    logic                 r_valve, n_valve;

    t_state               w_ph;
    t_state               w_shown;
    logic [TIME_BITS-1:0] w_base;
    logic [TIME_BITS-1:0] w_diff;
    logic                 w_hold;
    logic                 w_brew;
    logic                 w_delay_end;
    logic [MS_W-1:0]      w_elapsed;
    logic                 w_done;

    // A first pass restarts the timing base before the phase checks run.
    always_comb begin
        w_ph    = r_state;
        w_base  = r_start;
        n_pend  = r_pend;
        n_pump  = r_pump;
        n_valve = r_valve;
        w_hold  = 1'b0;
        if (i_first) begin
            w_base = i_now;
            n_pend = 1'b1;
            if (i_cfg.preinfusion_enable) begin
                w_ph    = S_PUMP;
                n_pump  = 1'b1;
                n_valve = 1'b1;
                w_hold  = 1'b1;
            end else if (w_ph != S_PUMP && w_ph != S_DELAY) begin
                w_ph = S_BREW;
            end
        end
        w_shown = w_ph;
        w_diff  = i_now - w_base;

        w_brew      = 1'b0;
        w_delay_end = 1'b0;
        n_start     = w_base;
        w_elapsed   = '0;
        w_done      = 1'b0;

        if (!w_hold) begin
            case (w_ph)
                S_PUMP: begin
                    if (w_diff >= TIME_BITS'(i_cfg.preinfusion_pump_ms)) begin
                        n_pump  = 1'b0;
                        n_valve = 1'b0;
                        w_ph    = S_DELAY;
                        n_start = i_now;
                    end
                end
                S_DELAY: begin
                    if (w_diff >= TIME_BITS'(i_cfg.preinfusion_delay_ms)) begin
                        w_ph        = S_BREW;
                        n_start     = i_now;
                        w_brew      = 1'b1;
                        w_delay_end = 1'b1;
                    end
                end
                S_BREW:  w_brew = 1'b1;
                default: w_brew = 1'b0;
            endcase
        end

        // The pass that ends the delay also takes the first brewing step at zero.
        if (w_brew) begin
            w_shown = S_BREW;
            if (n_pend) begin
                n_pend  = 1'b0;
                n_pump  = 1'b1;
                n_valve = 1'b1;
            end
            w_elapsed = w_delay_end ? '0 : w_diff[MS_W-1:0];
            if (i_cfg.brew_timer_enable && w_elapsed >= i_cfg.brew_limit_ms) begin
                n_pump  = 1'b0;
                n_valve = 1'b0;
                w_ph    = S_IDLE;
                w_done  = 1'b1;
            end
        end
        n_state = w_ph;

        o_res.pump_on    = n_pump;
        o_res.valve_on   = n_valve;
        o_res.phase      = w_shown;
        o_res.elapsed_ms = w_elapsed;
        o_res.brew_done  = w_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= '0;
            r_pend  <= 1'b0;
            r_pump  <= 1'b0;
            r_valve <= 1'b0;
        end else if (i_step) begin
            r_state <= n_state;
            r_start <= n_start;
            r_pend  <= n_pend;
            r_pump  <= n_pump;
            r_valve <= n_valve;
        end
    end

    `BPS_ASSERT_IMPL(a_done_drops_relays, i_clk, i_rst_n, o_res.brew_done,
        !o_res.pump_on && !o_res.valve_on && o_res.phase == PH_BREW,
        "brew done without relays off in brew phase")
    `BPS_ASSERT_IMPL(a_elapsed_only_brew, i_clk, i_rst_n, o_res.elapsed_ms != '0,
        o_res.phase == PH_BREW, "elapsed time reported outside brew phase")
    `BPS_ASSERT_NEXT(a_done_goes_idle, i_clk, i_rst_n, i_step && o_res.brew_done,
        r_state == S_IDLE, "cycle did not return to idle after brew done")
    `BPS_ASSERT_NEXT(a_brew_clears_pend, i_clk, i_rst_n, i_step && o_res.phase == PH_BREW,
        !r_pend, "relay switch-on still pending after a brewing step")

endmodule

// ===== hdl/brew_preinfusion_sequencer.sv =====
// Top level of the brew pre-infusion sequencer: channels, config port, pipeline.
//
// Usage: every pass of the brew routine is sent as one word on i_in, carrying the
// free-running millisecond time (now_ms) and a first-pass flag. Each input word
// yields exactly one result word on o_out: relay levels, the last phase in which the
// pass ran, the 16-bit brew elapsed time and a brew-done flag.
// Each accepted pass is held in the input register until the result slot frees;
// the phase logic then writes the result register, which offers the result word
// on o_out until the receiver takes it.
// One word per cycle is taken while the receiver does not stall; the phase logic
// is a single subtract and a set of compares between the input and result registers.
// Configuration registers are written through i_cfg_we, i_cfg_idx and i_cfg_data,
// one register per cycle; the user must write them only while no pass is in flight,
// as the block has no check for it. When the receiver stalls, the result register
// holds its word and the input register keeps one more pass; i_in.ready falls only
// when both are full. Synchronous reset clears the configuration to zero, returns
// the cycle to idle with both relays off and empties both registers.
module brew_preinfusion_sequencer #(
    parameter int TIME_BITS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    bps_in_if.sink                    i_in,
    bps_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [bps_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [bps_pkg::CFG_W-1:0] i_cfg_data
);
    import bps_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;

    // Input register: one pass waiting for the phase logic.
    logic                 r_in_valid;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_first;

    // Result register: one finished word waiting for the receiver.
    logic    r_out_valid;
    t_result r_res;

    logic w_advance;
    logic w_in_ready;

    // The phase logic fires whenever a pass is waiting and the result slot frees.
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_advance;

    bps_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bps_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_now   (r_now),
        .i_first (r_first),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Payload needs no reset; it is only used under r_in_valid.
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_now   <= i_in.now_ms;
            r_first <= i_in.first_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= w_res;
        end
    end

    assign i_in.ready       = w_in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.pump_on    = r_res.pump_on;
    assign o_out.valve_on   = r_res.valve_on;
    assign o_out.phase      = r_res.phase;
    assign o_out.elapsed_ms = r_res.elapsed_ms;
    assign o_out.brew_done  = r_res.brew_done;

endmodule

// ===== tb/tb_brew_preinfusion_sequencer.sv =====
// Self-checking testbench for the brew pre-infusion sequencer top level.
`timescale 1ns / 1ps

module tb_brew_preinfusion_sequencer;
    import bps_pkg::*;

    localparam int TIME_BITS         = 32;
    // A healthy block never goes this many cycles without moving a word on
    // either channel, even with the receiver parked for the long stall below.
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int LONG_STALL_CYCLES = 300;
    // The result reaches the receiver through the input and result registers, so
    // this many extra cycles are enough to be sure nothing else is coming out.
    localparam int SETTLE_CYCLES     = 6;
    localparam int SEGMENT_PASSES    = 50;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    bps_in_if #(.TIME_BITS(TIME_BITS)) in_if ();
    bps_out_if out_if ();

    brew_preinfusion_sequencer #(
        .TIME_BITS(TIME_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow of the brew cycle as the block should hold it. The configuration
    // copy is updated once all five register writes are done, so the predictor always
    // sees the same settings as the block for the passes that follow.
    t_cfg                 shadow_cfg  = '0;
    logic [1:0]           seq_phase   = PH_IDLE;
    logic [TIME_BITS-1:0] brew_start  = '0;
    logic                 relays_owed = 1'b0;
    logic                 pump_level  = 1'b0;
    logic                 valve_level = 1'b0;

    // Result reports predicted for passes already taken, oldest first.
    t_result predicted_reports[$];

    int  mismatches      = 0;
    int  send_idle_pct   = 0;
    int  recv_idle_pct   = 0;
    bit  long_stall_req  = 1'b0;
    int  stall_left      = 0;
    int  quiet_cycles    = 0;

    // Works out the report for one pass and advances the shadow cycle. The
    // order of the checks matters: a pass can end the pump phase and stop
    // there, while the pass that ends the delay phase goes on into its first
    // brewing step in the same pass.
    function automatic t_result predict_pass(input logic [TIME_BITS-1:0] now,
                                             input logic first);
        t_result              rep;
        logic [1:0]           shown;
        logic [TIME_BITS-1:0] span;
        logic [MS_W-1:0]      elapsed;
        logic                 done;
        logic                 settled;
        shown   = seq_phase;
        elapsed = '0;
        done    = 1'b0;
        settled = 1'b0;
        if (first) begin
            brew_start  = now;
            relays_owed = 1'b1;
            if (shadow_cfg.preinfusion_enable) begin
                seq_phase   = PH_PUMP;
                pump_level  = 1'b1;
                valve_level = 1'b1;
                settled     = 1'b1;
            end else if (seq_phase != PH_PUMP && seq_phase != PH_DELAY) begin
                // A restart with pre-infusion off keeps a pending pump or
                // delay phase and only retimes it from the new start.
                seq_phase = PH_BREW;
            end
            shown = seq_phase;
        end
        if (!settled && seq_phase == PH_PUMP) begin
            span = now - brew_start;
            if (span >= shadow_cfg.preinfusion_pump_ms) begin
                pump_level  = 1'b0;
                valve_level = 1'b0;
                seq_phase   = PH_DELAY;
                brew_start  = now;
            end
            settled = 1'b1;
        end
        if (!settled && seq_phase == PH_DELAY) begin
            span = now - brew_start;
            if (span < shadow_cfg.preinfusion_delay_ms) begin
                settled = 1'b1;
            end else begin
                seq_phase  = PH_BREW;
                brew_start = now;
            end
        end
        if (!settled && seq_phase == PH_BREW) begin
            shown = PH_BREW;
            if (relays_owed) begin
                relays_owed = 1'b0;
                pump_level  = 1'b1;
                valve_level = 1'b1;
            end
            span    = now - brew_start;
            elapsed = span[MS_W-1:0];
            if (shadow_cfg.brew_timer_enable && elapsed >= shadow_cfg.brew_limit_ms) begin
                pump_level  = 1'b0;
                valve_level = 1'b0;
                seq_phase   = PH_IDLE;
                done        = 1'b1;
            end
        end
        rep.pump_on    = pump_level;
        rep.valve_on   = valve_level;
        rep.phase      = shown;
        rep.elapsed_ms = (shown == PH_BREW) ? elapsed : '0;
        rep.brew_done  = done;
        return rep;
    endfunction

    function automatic t_cfg make_cfg(input logic pi_en, input int pump_ms,
                                      input int delay_ms, input logic bt_en,
                                      input int limit_ms);
        t_cfg c;
        c.preinfusion_enable   = pi_en;
        c.preinfusion_pump_ms  = pump_ms[MS_W-1:0];
        c.preinfusion_delay_ms = delay_ms[MS_W-1:0];
        c.brew_timer_enable    = bt_en;
        c.brew_limit_ms        = limit_ms[MS_W-1:0];
        return c;
    endfunction

    // Mostly short phase times so that random cycles run all the way through,
    // with the extremes and full-range values mixed in.
    function automatic int pick_ms();
        case ($urandom_range(9))
            0: return 0;
            1: return 65535;
            2: return $urandom_range(0, 65535);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    // Time advance between two passes of one cycle: usually a few ms, now
    // and then enough to wrap the 16-bit elapsed count or the full clock.
    function automatic logic [TIME_BITS-1:0] pick_step();
        case ($urandom_range(49))
            0: return $urandom;
            1, 2, 3, 4: return $urandom_range(0, 70000);
            default: return $urandom_range(0, 12);
        endcase
    endfunction

    // Writes all five registers back to back, then drops the write enable.
    // Only called with nothing in flight.
    task automatic write_config(input t_cfg c);
        logic [CFG_W-1:0] vals[5];
        logic [IDX_W-1:0] idxs[5];
        idxs = '{REG_PI_ENABLE, REG_PI_PUMP, REG_PI_DELAY, REG_BT_ENABLE, REG_BT_LIMIT};
        vals = '{CFG_W'(c.preinfusion_enable), c.preinfusion_pump_ms,
                 c.preinfusion_delay_ms, CFG_W'(c.brew_timer_enable), c.brew_limit_ms};
        for (int k = 0; k < 5; k++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idxs[k];
            cfg_data <= vals[k];
            @(posedge clk);
        end
        shadow_cfg = c;
        cfg_we <= 1'b0;
    endtask

    // Offers one pass word, optionally after a random gap, and records the
    // predicted report once the block takes it. Valid is left high so that
    // back-to-back words need no extra cycle.
    task automatic send_pass(input logic [TIME_BITS-1:0] now, input logic first);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.now_ms     <= now;
        in_if.first_pass <= first;
        do @(posedge clk); while (!in_if.ready);
        predicted_reports.push_back(predict_pass(now, first));
    endtask

    // Stops offering words and waits until every predicted report is back,
    // then a few more cycles so that a stray extra word would be seen.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (predicted_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random brew cycles: most are well-formed (a first pass at a random time,
    // then passes with rising time), some carry a restart in the middle, and
    // a tenth of the draws send one plain noise word instead.
    task automatic run_brew_cycles(input int n_passes);
        int                   sent;
        int                   len;
        logic [TIME_BITS-1:0] t;
        sent = 0;
        while (sent < n_passes) begin
            if ($urandom_range(9) == 0) begin
                send_pass($urandom, $urandom_range(3) == 0);
                sent++;
            end else begin
                t = $urandom;
                send_pass(t, 1'b1);
                sent++;
                len = $urandom_range(4, 24);
                for (int k = 0; k < len && sent < n_passes; k++) begin
                    t += pick_step();
                    send_pass(t, $urandom_range(29) == 0);
                    sent++;
                end
            end
        end
    endtask

    // Reset settings first: idle passes at both ends of the time range, then
    // a plain brew cycle whose elapsed time crosses the clock wrap.
    task automatic test_idle_and_wrap();
        send_pass(32'h0000_0000, 1'b0);
        send_pass(32'hFFFF_FFFF, 1'b0);
        send_pass(32'hFFFF_FFF0, 1'b1);
        send_pass(32'h0000_000F, 1'b0);
        drain();
    endtask

    // A full cycle through pump, delay and timed brewing, ending in the done
    // pass and one idle pass after it.
    task automatic test_preinfusion_sequence();
        write_config(make_cfg(1'b1, 3, 2, 1'b1, 4));
        send_pass(32'd1000, 1'b1);
        send_pass(32'd1001, 1'b0);
        send_pass(32'd1003, 1'b0);
        send_pass(32'd1004, 1'b0);
        send_pass(32'd1005, 1'b0);
        send_pass(32'd1007, 1'b0);
        send_pass(32'd1009, 1'b0);
        send_pass(32'd1010, 1'b0);
        drain();
    endtask

    // Restart inside the pump phase after pre-infusion has been switched off:
    // the pump phase is kept and retimed. A zero delay then makes the pass
    // that ends the delay also the first brewing pass.
    task automatic test_restart_in_preinfusion();
        write_config(make_cfg(1'b1, 100, 0, 1'b0, 0));
        send_pass(32'd0, 1'b1);
        drain();
        write_config(make_cfg(1'b0, 100, 0, 1'b0, 0));
        send_pass(32'd50, 1'b1);
        send_pass(32'd149, 1'b0);
        send_pass(32'd150, 1'b0);
        send_pass(32'd150, 1'b0);
        drain();
    endtask

    // With the timer on and a zero limit the first brewing pass ends the cycle.
    task automatic test_zero_limit();
        write_config(make_cfg(1'b0, 0, 0, 1'b1, 0));
        send_pass(32'd12345, 1'b1);
        send_pass(32'd12346, 1'b0);
        drain();
    endtask

    // All times at their maximum, starting just below the clock wrap.
    task automatic test_extreme_times();
        logic [TIME_BITS-1:0] t;
        write_config(make_cfg(1'b1, 65535, 65535, 1'b1, 65535));
        t = 32'hFFFF_0000;
        send_pass(t, 1'b1);
        send_pass(t + 32'd65534, 1'b0);
        t += 32'd65535;
        send_pass(t, 1'b0);
        send_pass(t + 32'd65534, 1'b0);
        t += 32'd65535;
        send_pass(t, 1'b0);
        send_pass(t + 32'd65535, 1'b0);
        drain();
    endtask

    // Random traffic in segments; the settings change between segments while
    // a cycle may still be pending, so changes take effect mid-cycle too.
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_passes);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int done_passes = 0; done_passes < n_passes; done_passes += SEGMENT_PASSES) begin
            write_config(make_cfg(1'($urandom_range(1)), pick_ms(), pick_ms(),
                                  1'($urandom_range(1)), pick_ms()));
            run_brew_cycles(SEGMENT_PASSES);
            drain();
        end
    endtask

    // The receiver parks for a long stretch while the sender keeps offering
    // words, so both internal registers fill and the input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_config(make_cfg(1'b1, 5, 3, 1'b1, 10));
        long_stall_req = 1'b1;
        run_brew_cycles(40);
        drain();
    endtask

    // Receiver: random stalls at the current rate, or a long stall on request.
    always @(posedge clk) begin
        if (long_stall_req) begin
            long_stall_req = 1'b0;
            stall_left     = LONG_STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Result checker: every word taken from the block is matched against the
    // oldest predicted report, field by field.
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (predicted_reports.size() == 0) begin
                $error("result word with no pass awaiting a report");
                mismatches++;
            end else begin
                want = predicted_reports.pop_front();
                if (out_if.pump_on !== want.pump_on) begin
                    $error("pump_on: expected %0d, got %0d", want.pump_on, out_if.pump_on);
                    mismatches++;
                end
                if (out_if.valve_on !== want.valve_on) begin
                    $error("valve_on: expected %0d, got %0d", want.valve_on, out_if.valve_on);
                    mismatches++;
                end
                if (out_if.phase !== want.phase) begin
                    $error("phase: expected %0d, got %0d", want.phase, out_if.phase);
                    mismatches++;
                end
                if (out_if.elapsed_ms !== want.elapsed_ms) begin
                    $error("elapsed_ms: expected %0d, got %0d",
                           want.elapsed_ms, out_if.elapsed_ms);
                    mismatches++;
                end
                if (out_if.brew_done !== want.brew_done) begin
                    $error("brew_done: expected %0d, got %0d", want.brew_done, out_if.brew_done);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: a hung handshake or a lost result shows up as a long run of
    // cycles in which neither channel moves a word.
    always @(posedge clk) begin
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("brew_preinfusion_sequencer verification failed");
            $finish;
        end
    end

    initial begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        in_if.valid      = 1'b0;
        in_if.now_ms     = '0;
        in_if.first_pass = 1'b0;
        out_if.ready     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_and_wrap();
        test_preinfusion_sequence();
        test_restart_in_preinfusion();
        test_zero_limit();
        test_extreme_times();
        test_random_traffic(30, 82, 250);
        test_random_traffic(82, 30, 250);
        test_random_traffic(0, 0, 250);
        test_backpressure();

        if (mismatches == 0) begin
            $display("brew_preinfusion_sequencer verification clean");
        end else begin
            $display("brew_preinfusion_sequencer verification failed");
        end
        $finish;
    end

endmodule
